// ===== src/sdfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfc_pkg
// Shared types and constants for the SDF CSG combine block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdfc_pkg;

    // width of the operation code field
    localparam int FUNC_W = 3;

    // operation codes; unused codes behave as union
    typedef enum logic [FUNC_W-1:0] {
        FUNC_UNION  = 3'd0,
        FUNC_SUB    = 3'd1,
        FUNC_INTER  = 3'd2,
        FUNC_SUNION = 3'd3,
        FUNC_SSUB   = 3'd4
    } t_func;

endpackage

// ===== src/sdfc_in_if.sv =====
// ----------------------------------------------------------------------------
// sdfc_in_if
// Voxel input channel: operation code, two distances and smoothing radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sdfc_in_if #(
    parameter int DIST_WIDTH = 24
);
    logic                         valid;
    logic                         ready;
    logic [sdfc_pkg::FUNC_W-1:0]  func;
    logic signed [DIST_WIDTH-1:0] dist_a;
    logic signed [DIST_WIDTH-1:0] dist_b;
    logic [DIST_WIDTH-2:0]        smooth_k;

    modport source (output valid, func, dist_a, dist_b, smooth_k, input ready);
    modport sink   (input valid, func, dist_a, dist_b, smooth_k, output ready);
endinterface

// ===== src/sdfc_out_if.sv =====
// ----------------------------------------------------------------------------
// sdfc_out_if
// Result channel: combined distance and blend factor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sdfc_out_if #(
    parameter int DIST_WIDTH = 24,
    parameter int FRAC_BITS  = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [DIST_WIDTH-1:0] distance;
    logic signed [FRAC_BITS+1:0]  blend_t;

    modport source (output valid, distance, blend_t, input ready);
    modport sink   (input valid, distance, blend_t, output ready);
endinterface

// ===== src/sdfc_div.sv =====
// ----------------------------------------------------------------------------
// sdfc_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// floor((rem << (QW-1)) / den) for rem <= den, with a sideband word that
// travels alongside. Each stage has its own valid bit and fills bubbles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdfc_div #(
    parameter int KW  = 23,
    parameter int QW  = 13,
    parameter int SBW = 27
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  logic [KW-1:0]  i_rem,
    input  logic [KW-1:0]  i_den,
    input  logic [SBW-1:0] i_sb,
    output logic           o_vld,
    input  logic           i_rdy,
    output logic [QW-1:0]  o_quo,
    output logic [KW-1:0]  o_den,
    output logic [SBW-1:0] o_sb
);

    localparam int NS = QW;

    // stage registers
    logic           r_vld [NS];
    logic [KW-1:0]  r_rem [NS];
    logic [KW-1:0]  r_den [NS];
    logic [QW-1:0]  r_quo [NS];
    logic [SBW-1:0] r_sb  [NS];

    // stage inputs: index 0 is the port, index j+1 is stage j
    logic           c_vld [NS+1];
    logic [KW-1:0]  c_rem [NS+1];
    logic [KW-1:0]  c_den [NS+1];
    logic [QW-1:0]  c_quo [NS+1];
    logic [SBW-1:0] c_sb  [NS+1];
    logic           c_rdy [NS+1];

    assign c_vld[0] = i_vld;
    assign c_rem[0] = i_rem;
    assign c_den[0] = i_den;
    assign c_quo[0] = '0;
    assign c_sb[0]  = i_sb;
    assign c_rdy[NS] = i_rdy;
    assign o_rdy    = c_rdy[0];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [KW:0]   trial;
        logic [KW:0]   diff;
        logic          qbit;
        logic [KW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        // first step compares the remainder as is, later steps shift it
        if (j == 0) begin : g_first
            assign trial = {1'b0, c_rem[j]};
        end else begin : g_next
            assign trial = {c_rem[j], 1'b0};
        end

        always_comb begin
            diff  = trial - {1'b0, c_den[j]};
            qbit  = (trial >= {1'b0, c_den[j]});
            n_rem = qbit ? diff[KW-1:0] : trial[KW-1:0];
            n_quo = {c_quo[j][QW-2:0], qbit};
        end

        assign c_rdy[j] = !r_vld[j] || c_rdy[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (c_rdy[j]) begin
                r_vld[j] <= c_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (c_rdy[j]) begin
                r_rem[j] <= n_rem;
                r_den[j] <= c_den[j];
                r_quo[j] <= n_quo;
                r_sb[j]  <= c_sb[j];
            end
        end

        assign c_vld[j+1] = r_vld[j];
        assign c_rem[j+1] = r_rem[j];
        assign c_den[j+1] = r_den[j];
        assign c_quo[j+1] = r_quo[j];
        assign c_sb[j+1]  = r_sb[j];
    end

    assign o_vld = c_vld[NS];
    assign o_quo = c_quo[NS];
    assign o_den = c_den[NS];
    assign o_sb  = c_sb[NS];

    // the final remainder of a real division stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && (r_den[NS-1] != '0)) |-> (r_rem[NS-1] < r_den[NS-1]))
        else $error("divider remainder not below divisor");

endmodule

// ===== src/sdf_csg_combine.sv =====
// ----------------------------------------------------------------------------
// sdf_csg_combine
// Stages: two operand stages, FRAC_BITS + 1 divider stages for the smooth
// factor h, and square, scale and output stages.
// Throughput: one voxel per cycle unless the output stalls; every stage has its own valid bit.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdf_csg_combine #(
    parameter int FRAC_BITS  = 12,
    parameter int DIST_WIDTH = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sdfc_in_if.sink    i_in,
    sdfc_out_if.source o_out
);

    localparam int DW  = DIST_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int KW  = DW - 1;      // smoothing radius
    localparam int XW  = DW + 1;      // operands, -a held exactly
    localparam int HW  = FB + 1;      // h, up to 1.0
    localparam int MW  = FB;          // m, up to 0.5
    localparam int TW  = FB + 2;      // blend factor
    localparam int PW  = MW + KW;     // m * k product
    localparam int SW  = PW - FB - 1; // scaled s
    localparam int SBW = XW + 2;      // divider sideband: act, tone, dsel
    localparam int EW  = XW + 1 - SW; // zero extension of s

    localparam logic [HW-1:0]        H_ONE = {1'b1, {FB{1'b0}}};
    localparam logic signed [TW-1:0] T_ONE = {2'b01, {FB{1'b0}}};
    localparam logic signed [TW-1:0] T_MIN = {3'b111, {(FB-1){1'b0}}};
    localparam logic [DW-1:0]        D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]        D_MIN = {1'b1, {(DW-1){1'b0}}};

    // ------------------------------------------------------------------
    // stage 1: decode operation, negate A for subtraction
    // ------------------------------------------------------------------
    logic          s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
    logic          r_s1_vld;
    logic [XW-1:0] r_s1_x, r_s1_y;
    logic [KW-1:0] r_s1_k;
    logic          r_s1_smooth, r_s1_max;
    logic [XW-1:0] n_s1_x, a_ext;
    logic          n_s1_neg, n_s1_smooth, n_s1_max;

    always_comb begin
        n_s1_neg    = (i_in.func == sdfc_pkg::FUNC_SUB)    ||
                      (i_in.func == sdfc_pkg::FUNC_SSUB);
        n_s1_smooth = (i_in.func == sdfc_pkg::FUNC_SUNION) ||
                      (i_in.func == sdfc_pkg::FUNC_SSUB);
        n_s1_max    = (i_in.func == sdfc_pkg::FUNC_SUB)    ||
                      (i_in.func == sdfc_pkg::FUNC_INTER);
        a_ext       = {i_in.dist_a[DW-1], i_in.dist_a};
        n_s1_x      = n_s1_neg ? (~a_ext + 1'b1) : a_ext;
    end

    assign s1_rdy     = !r_s1_vld || s2_rdy;
    assign i_in.ready = s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_x      <= n_s1_x;
            r_s1_y      <= {i_in.dist_b[DW-1], i_in.dist_b};
            r_s1_k      <= i_in.smooth_k;
            r_s1_smooth <= n_s1_smooth;
            r_s1_max    <= n_s1_max;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: compare, select, |x-y| and the divider numerator
    // ------------------------------------------------------------------
    logic          r_s2_vld;
    logic [XW-1:0] r_s2_dsel;
    logic          r_s2_tone, r_s2_act;
    logic [KW-1:0] r_s2_rem, r_s2_k;
    logic [XW:0]   diff;
    logic [XW-1:0] ad;
    logic          f, n_s2_act, n_s2_tone;
    logic [XW-1:0] n_s2_dsel;
    logic [KW-1:0] n_s2_rem;
    logic          div_rdy;

    always_comb begin
        f    = $signed(r_s1_x) > $signed(r_s1_y);
        diff = {r_s1_x[XW-1], r_s1_x} - {r_s1_y[XW-1], r_s1_y};
        ad   = diff[XW] ? XW'(~diff + 1'b1) : diff[XW-1:0];
        n_s2_act = r_s1_smooth && (r_s1_k != '0) &&
                   (ad < {2'b00, r_s1_k});
        // inactive items divide zero, keeping rem <= den in the divider
        n_s2_rem = n_s2_act ? (r_s1_k - ad[KW-1:0]) : '0;
        if (r_s1_max) begin
            n_s2_dsel = f ? r_s1_x : r_s1_y;
            n_s2_tone = !f;
        end else begin
            n_s2_dsel = f ? r_s1_y : r_s1_x;
            n_s2_tone = f;
        end
    end

    assign s2_rdy = !r_s2_vld || div_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_s2_dsel <= n_s2_dsel;
            r_s2_tone <= n_s2_tone;
            r_s2_act  <= n_s2_act;
            r_s2_rem  <= n_s2_rem;
            r_s2_k    <= r_s1_k;
        end
    end

    // ------------------------------------------------------------------
    // divider: h = (r << FB) / k
    // ------------------------------------------------------------------
    logic           div_vld;
    logic [HW-1:0]  div_quo;
    logic [KW-1:0]  div_den;
    logic [SBW-1:0] div_sb;

    sdfc_div #(
        .KW  (KW),
        .QW  (HW),
        .SBW (SBW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .o_rdy   (div_rdy),
        .i_rem   (r_s2_rem),
        .i_den   (r_s2_k),
        .i_sb    ({r_s2_act, r_s2_tone, r_s2_dsel}),
        .o_vld   (div_vld),
        .i_rdy   (s3_rdy),
        .o_quo   (div_quo),
        .o_den   (div_den),
        .o_sb    (div_sb)
    );

    // ------------------------------------------------------------------
    // stage 3: m = h*h / 2
    // ------------------------------------------------------------------
    logic            r_s3_vld;
    logic [MW-1:0]   r_s3_m;
    logic [KW-1:0]   r_s3_k;
    logic [XW-1:0]   r_s3_dsel;
    logic            r_s3_tone, r_s3_act;
    logic [2*HW-1:0] sq;
    logic [MW-1:0]   n_s3_m;

    always_comb begin
        sq     = div_quo * div_quo;
        n_s3_m = div_sb[SBW-1] ? sq[2*FB:FB+1] : '0;
    end

    assign s3_rdy = !r_s3_vld || s4_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (s3_rdy) begin
            r_s3_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_rdy) begin
            r_s3_m    <= n_s3_m;
            r_s3_k    <= div_den;
            r_s3_dsel <= div_sb[XW-1:0];
            r_s3_tone <= div_sb[XW];
            r_s3_act  <= div_sb[SBW-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: s = m*k / 2
    // ------------------------------------------------------------------
    logic          r_s4_vld;
    logic [SW-1:0] r_s4_s;
    logic [MW-1:0] r_s4_m;
    logic [XW-1:0] r_s4_dsel;
    logic          r_s4_tone, r_s4_act;
    logic [PW-1:0] prod;

    assign prod   = r_s3_m * r_s3_k;
    assign s4_rdy = !r_s4_vld || s5_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (s4_rdy) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_rdy) begin
            r_s4_s    <= prod[PW-1:FB+1];
            r_s4_m    <= r_s3_m;
            r_s4_dsel <= r_s3_dsel;
            r_s4_tone <= r_s3_tone;
            r_s4_act  <= r_s3_act;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: final distance with saturation, blend factor; output reg
    // ------------------------------------------------------------------
    logic          r_s5_vld;
    logic [DW-1:0] r_s5_dist;
    logic [TW-1:0] r_s5_t;
    logic [XW:0]   dfull;
    logic [DW-1:0] n_s5_dist;
    logic [TW-1:0] n_s5_t;
    logic          in_range;

    always_comb begin
        dfull    = {r_s4_dsel[XW-1], r_s4_dsel} - {{EW{1'b0}}, r_s4_s};
        in_range = (dfull[XW:DW-1] == '0) || (dfull[XW:DW-1] == '1);
        if (in_range) begin
            n_s5_dist = dfull[DW-1:0];
        end else begin
            n_s5_dist = dfull[XW] ? D_MIN : D_MAX;
        end
        n_s5_t = (r_s4_tone ? T_ONE : '0) - {2'b00, r_s4_m};
    end

    assign s5_rdy = !r_s5_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (s5_rdy) begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_rdy) begin
            r_s5_dist <= n_s5_dist;
            r_s5_t    <= n_s5_t;
        end
    end

    assign o_out.valid    = r_s5_vld;
    assign o_out.distance = r_s5_dist;
    assign o_out.blend_t  = r_s5_t;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // smooth factor never exceeds 1.0 for an active smooth voxel
    a_h_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_vld && div_sb[SBW-1]) |-> (div_quo <= H_ONE))
        else $error("smooth factor h above one");

    // hard voxels carry no smoothing correction
    a_hard_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_vld && !r_s4_act) |-> ((r_s4_s == '0) && (r_s4_m == '0)))
        else $error("hard voxel picked up a smoothing term");

    // blend factor stays within [-0.5, 1.0]
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s5_vld |-> (($signed(r_s5_t) >= T_MIN) && ($signed(r_s5_t) <= T_ONE)))
        else $error("blend factor out of range");

    // a new result only appears when the previous stage held one
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s5_vld) |-> $past(r_s4_vld))
        else $error("output valid without a source transaction");

endmodule
